// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the sonar reading averager. The checks are
// compiled for simulation only and vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define SRA_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define SRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SRA_ASSERT(label, clk, rst_n, expr, msg)
`define SRA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SRA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager package
// Character codes, field widths and the token type passed from the byte
// parser to the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

    // Character codes of the sonar text.
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 14;
    localparam int MIN_W       = 6;
    localparam int COUNT_OUT_W = 6;

    // Largest reading value (four digits).
    localparam int MAX_VALUE = 9999;

    // Reading window: fill is 0 when idle, else 1 plus the bytes consumed.
    localparam int              FILL_W    = 3;
    localparam logic [FILL_W-1:0] FILL_IDLE = 3'd0;
    localparam logic [FILL_W-1:0] FILL_OPEN = 3'd1;
    localparam logic [FILL_W-1:0] FILL_LAST = 3'd4;

    // Marker spacing counter, saturating.
    localparam int              SINCE_W   = 2;
    localparam logic [SINCE_W-1:0] SINCE_MAX = 2'd3;
    localparam logic [SINCE_W-1:0] SINCE_ARM = 2'd2;

    // Register reset value.
    localparam logic [MIN_W-1:0] MIN_RESET = 6'd4;

    // Token queue between parser and accumulator.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // One token: a finished reading, a frame end, or both.
    typedef struct packed {
        logic               last;
        logic               has_rd;
        logic [VALUE_W-1:0] value;
    } t_tok;

endpackage

`default_nettype wire

// ===== rtl/sra_if.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager channels
// Valid/ready channels for the byte input, the result output and the
// threshold register write.
// ----------------------------------------------------------------------------
`default_nettype none

// Byte input channel.
interface sra_in_if;
    logic                      valid;
    logic                      ready;
    logic [sra_pkg::BYTE_W-1:0] data_byte;
    logic                      frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// Result output channel.
interface sra_out_if;
    logic                           valid;
    logic                           ready;
    logic [sra_pkg::VALUE_W-1:0]     distance;
    logic                           average_valid;
    logic [sra_pkg::COUNT_OUT_W-1:0] reading_count;

    modport source (output valid, output distance, output average_valid,
                    output reading_count, input ready);
    modport sink   (input valid, input distance, input average_valid,
                    input reading_count, output ready);
endinterface

// Threshold register write channel.
interface sra_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [sra_pkg::MIN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sra_front.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager byte parser
// Tracks markers and the two reading windows, one byte per cycle while the
// queue has room; emits a token per well-formed reading and per frame end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sra_in_if.sink             i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output sra_pkg::t_tok      o_tok
);

    logic [sra_pkg::FILL_W-1:0]  r_fill  [2];
    logic [sra_pkg::FILL_W-1:0]  n_fill  [2];
    logic [sra_pkg::VALUE_W-1:0] r_value [2];
    logic [sra_pkg::VALUE_W-1:0] n_value [2];
    logic [1:0]                  r_bad;
    logic [1:0]                  n_bad;
    logic [1:0]                  r_dot;
    logic [1:0]                  n_dot;
    logic [sra_pkg::SINCE_W-1:0] r_since;
    logic [sra_pkg::SINCE_W-1:0] n_since;

    logic                        w_accept;
    logic                        w_is_digit;
    logic                        w_is_dot;
    logic [sra_pkg::VALUE_W+3:0] w_prod;
    logic                        w_done;
    logic [sra_pkg::VALUE_W-1:0] w_done_val;

    // A byte is taken whenever the token queue has room.
    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    assign w_is_digit = (i_in.data_byte >= sra_pkg::CH_0) && (i_in.data_byte <= sra_pkg::CH_9);
    assign w_is_dot   = (i_in.data_byte == sra_pkg::CH_DOT);

    // Feed open windows, then decide whether this byte opens a new one.
    always_comb begin
        n_fill     = r_fill;
        n_value    = r_value;
        n_bad      = r_bad;
        n_dot      = r_dot;
        n_since    = r_since;
        w_prod     = '0;
        w_done     = 1'b0;
        w_done_val = '0;
        if (w_accept) begin
            for (int k = 0; k < 2; k++) begin
                if (r_fill[k] != sra_pkg::FILL_IDLE) begin
                    if (w_is_digit) begin
                        if (!r_dot[k]) begin
                            w_prod = ({4'b0, r_value[k]} << 3) + ({4'b0, r_value[k]} << 1)
                                   + {{(sra_pkg::VALUE_W){1'b0}}, i_in.data_byte[3:0]};
                            n_value[k] = w_prod[sra_pkg::VALUE_W-1:0];
                        end
                    end else if (w_is_dot) begin
                        if (r_dot[k]) begin
                            n_bad[k] = 1'b1;
                        end
                        n_dot[k] = 1'b1;
                    end else begin
                        n_bad[k] = 1'b1;
                    end
                    if (r_fill[k] == sra_pkg::FILL_LAST) begin
                        if (!n_bad[k]) begin
                            w_done     = 1'b1;
                            w_done_val = n_value[k];
                        end
                        n_fill[k]  = sra_pkg::FILL_IDLE;
                        n_value[k] = '0;
                        n_bad[k]   = 1'b0;
                        n_dot[k]   = 1'b0;
                    end else begin
                        n_fill[k] = r_fill[k] + 1'b1;
                    end
                end
            end

            // Marker counts only when spaced at least three bytes from the last one.
            if ((i_in.data_byte == sra_pkg::CH_R) && (r_since >= sra_pkg::SINCE_ARM)) begin
                n_since = '0;
                if (n_fill[0] == sra_pkg::FILL_IDLE) begin
                    n_fill[0] = sra_pkg::FILL_OPEN;
                end else if (n_fill[1] == sra_pkg::FILL_IDLE) begin
                    n_fill[1] = sra_pkg::FILL_OPEN;
                end
            end else if (r_since != sra_pkg::SINCE_MAX) begin
                n_since = r_since + 1'b1;
            end

            // The frame's last byte drops unfinished windows.
            if (i_in.frame_end) begin
                for (int k = 0; k < 2; k++) begin
                    n_fill[k]  = sra_pkg::FILL_IDLE;
                    n_value[k] = '0;
                end
                n_bad   = '0;
                n_dot   = '0;
                n_since = sra_pkg::SINCE_MAX;
            end
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill[0]  <= sra_pkg::FILL_IDLE;
            r_fill[1]  <= sra_pkg::FILL_IDLE;
            r_value[0] <= '0;
            r_value[1] <= '0;
            r_bad      <= '0;
            r_dot      <= '0;
            r_since    <= sra_pkg::SINCE_MAX;
        end else begin
            r_fill  <= n_fill;
            r_value <= n_value;
            r_bad   <= n_bad;
            r_dot   <= n_dot;
            r_since <= n_since;
        end
    end

    // Token toward the accumulator.
    assign o_push       = w_accept && (w_done || i_in.frame_end);
    assign o_tok.last   = i_in.frame_end;
    assign o_tok.has_rd = w_done;
    assign o_tok.value  = w_done_val;

    // Overlapping windows are always at different offsets.
    `SRA_ASSERT_IMP(a_fill_apart, i_clk, i_rst_n, (r_fill[0] != sra_pkg::FILL_IDLE) && (r_fill[1] != sra_pkg::FILL_IDLE), r_fill[0] != r_fill[1], "both windows at the same offset")
    // A counted marker always finds a free window.
    `SRA_ASSERT_IMP(a_marker_open, i_clk, i_rst_n, r_since == '0, (r_fill[0] == sra_pkg::FILL_OPEN) || (r_fill[1] == sra_pkg::FILL_OPEN), "counted marker without an open window")
    // Window fill never passes its last byte.
    `SRA_ASSERT(a_fill_range, i_clk, i_rst_n, (r_fill[0] <= sra_pkg::FILL_LAST) && (r_fill[1] <= sra_pkg::FILL_LAST), "window fill out of range")

endmodule

`default_nettype wire

// ===== rtl/sra_queue.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager token queue
// Small first-in first-out buffer that lets the parser keep taking bytes
// while the accumulator finishes a frame.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sra_pkg::t_tok      i_tok,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output sra_pkg::t_tok      o_tok
);

    sra_pkg::t_tok             r_mem [sra_pkg::QUEUE_DEPTH];
    logic [sra_pkg::QPTR_W-1:0] r_wr;
    logic [sra_pkg::QPTR_W-1:0] r_rd;
    logic [sra_pkg::QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (sra_pkg::QPTR_W+1)'(sra_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SRA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "push into a full queue")
    `SRA_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid, "pop from an empty queue")
    `SRA_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "occupancy did not grow on push")

endmodule

`default_nettype wire

// ===== rtl/sra_back.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager accumulator
// Sums the readings before the first zero, and at a frame end that gives a mean
// divides the sum by their count with a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_back #(
    parameter int MAX_READINGS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sra_cfg_if.sink            i_cfg,
    input  wire logic          i_tok_valid,
    input  sra_pkg::t_tok      i_tok,
    output logic               o_pop,
    sra_out_if.source          o_out
);

    localparam int CNT_W  = $clog2(MAX_READINGS + 1);
    localparam int SUM_W  = $clog2(MAX_READINGS * sra_pkg::MAX_VALUE + 1);
    localparam int STEP_W = $clog2(SUM_W);
    localparam int CMP_W  = CNT_W + sra_pkg::MIN_W;

    typedef enum logic [2:0] {
        ST_ACC = 3'b001,
        ST_DIV = 3'b010,
        ST_OUT = 3'b100
    } t_state;

    t_state                     r_state;
    logic [sra_pkg::MIN_W-1:0]  r_min;

    // Frame accumulators.
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           n_sum;
    logic [CNT_W-1:0]           r_pcount;
    logic [CNT_W-1:0]           n_pcount;
    logic [CNT_W-1:0]           r_total;
    logic [CNT_W-1:0]           n_total;
    logic                       r_zero;
    logic                       n_zero;

    // Divider and result.
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [CNT_W-1:0]           r_div;
    logic [STEP_W-1:0]          r_step;
    logic                       r_avg;
    logic [CNT_W-1:0]           r_tcount;

    logic                       w_go;
    logic [CNT_W:0]             w_shift;
    logic [CNT_W:0]             w_diff;
    logic                       w_ge;
    logic [CNT_W+sra_pkg::COUNT_OUT_W-1:0] w_count_ext;

    // Threshold register: always ready.
    assign i_cfg.ready = 1'b1;

    assign o_pop = i_tok_valid && (r_state == ST_ACC);

    // Store one reading: dropped past the store limit, summed until a zero.
    always_comb begin
        n_sum    = r_sum;
        n_pcount = r_pcount;
        n_total  = r_total;
        n_zero   = r_zero;
        if (o_pop && i_tok.has_rd && (r_total < CNT_W'(MAX_READINGS))) begin
            n_total = r_total + 1'b1;
            if (!r_zero) begin
                if (i_tok.value == '0) begin
                    n_zero = 1'b1;
                end else begin
                    n_sum    = r_sum + SUM_W'(i_tok.value);
                    n_pcount = r_pcount + 1'b1;
                end
            end
        end
    end

    assign w_go = ({{(sra_pkg::MIN_W){1'b0}}, n_total} > CMP_W'(r_min)) && (n_pcount != '0);

    // One restoring division step.
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    // Control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ACC;
            r_min    <= sra_pkg::MIN_RESET;
            r_sum    <= '0;
            r_pcount <= '0;
            r_total  <= '0;
            r_zero   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_min <= i_cfg.data;
            end
            unique case (r_state)
                ST_ACC: begin
                    if (o_pop && i_tok.last) begin
                        r_quo    <= w_go ? n_sum : '0;
                        r_div    <= n_pcount;
                        r_rem    <= '0;
                        r_step   <= '0;
                        r_avg    <= w_go;
                        r_tcount <= n_total;
                        r_sum    <= '0;
                        r_pcount <= '0;
                        r_total  <= '0;
                        r_zero   <= 1'b0;
                        r_state  <= w_go ? ST_DIV : ST_OUT;
                    end else begin
                        r_sum    <= n_sum;
                        r_pcount <= n_pcount;
                        r_total  <= n_total;
                        r_zero   <= n_zero;
                    end
                end
                ST_DIV: begin
                    r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_state <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_ACC;
                end
            endcase
        end
    end

    // Result register.
    assign w_count_ext         = {{(sra_pkg::COUNT_OUT_W){1'b0}}, r_tcount};
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.distance      = r_quo[sra_pkg::VALUE_W-1:0];
    assign o_out.average_valid = r_avg;
    assign o_out.reading_count = w_count_ext[sra_pkg::COUNT_OUT_W-1:0];

    // A mean is never zero, and no mean means a zero distance.
    `SRA_ASSERT_IMP(a_dist_flag, i_clk, i_rst_n, o_out.valid, (o_out.distance != '0) == o_out.average_valid, "distance disagrees with average_valid")
    `SRA_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == ST_DIV, r_div != '0, "division by a zero count")
    `SRA_ASSERT(a_prefix_le_total, i_clk, i_rst_n, r_pcount <= r_total, "prefix count exceeds stored count")
    `SRA_ASSERT_NXT(a_out_done, i_clk, i_rst_n, o_out.valid && o_out.ready, r_state == ST_ACC, "accumulator did not resume after result beat")

endmodule

`default_nettype wire

// ===== rtl/sonar_reading_averager.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager
// Takes a sonar text frame one byte per beat and gives one result beat per
// frame after its last byte: the truncated mean of the well-formed readings
// that come before the first zero reading, the flag that a mean was given,
// and the number of readings stored. Bytes are taken at one per cycle while
// the queue has room; a parser turns them into reading and frame-end tokens,
// which pass through a four-entry queue to the accumulator. At a frame end
// the accumulator loads a restoring divider that gives one quotient bit per
// cycle over the SUM_W-bit sum, SUM_W = clog2(MAX_READINGS * 9999 + 1) (19 at
// the default); a frame with no mean skips the divider. The result register
// then holds the beat until it is taken. The parser keeps taking bytes of
// the next frame meanwhile and stalls only when the queue is full. Write the
// threshold register only while no frame is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_reading_averager #(
    parameter int MAX_READINGS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sra_in_if.sink    i_in,
    sra_cfg_if.sink   i_cfg,
    sra_out_if.source o_out
);

    logic          w_push;
    logic          w_full;
    logic          w_tok_valid;
    logic          w_pop;
    sra_pkg::t_tok w_tok_in;
    sra_pkg::t_tok w_tok_out;

    // Byte parser.
    sra_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_tok   (w_tok_in)
    );

    // Token queue.
    sra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_tok_in),
        .o_full  (w_full),
        .o_valid (w_tok_valid),
        .i_pop   (w_pop),
        .o_tok   (w_tok_out)
    );

    // Accumulator and divider.
    sra_back #(
        .MAX_READINGS (MAX_READINGS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok_out),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Sonar reading averager testbench
// Feeds sonar text frames into the byte channel and predicts the result beat
// of every frame from an independent model of the marker spacing, the two
// reading windows and the prefix mean. A few short hand-built frames are sent
// first, then random frames under a range of threshold settings, while both
// channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int STORE_LIMIT   = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES  = 1700;
    localparam int TIMEOUT_NS    = 4_000_000;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [sra_pkg::VALUE_W-1:0]     distance;
        logic                            average_valid;
        logic [sra_pkg::COUNT_OUT_W-1:0] reading_count;
    } t_range_result;

    // Receiver stall patterns.
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} t_rx_mode;

    // Ways a random reading is shaped.
    typedef enum int {
        SHAPE_ZERO, SHAPE_DOT, SHAPE_TWO_DOTS, SHAPE_BAD_BYTE,
        SHAPE_DOUBLE_R, SHAPE_OVERLAP, SHAPE_PLAIN
    } t_reading_shape;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sra_in_if  in_if();
    sra_cfg_if cfg_if();
    sra_out_if out_if();

    sonar_reading_averager #(
        .MAX_READINGS(STORE_LIMIT)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    // Model of the frame state and the threshold register.
    int marker_gap;
    int win_fill [2];
    int win_value [2];
    bit win_bad [2];
    bit win_dot [2];
    int prefix_total;
    int prefix_readings;
    int stored_readings;
    bit zero_reading_seen;
    int min_count;

    t_range_result expected_ranges [$];

    int burst_left;
    int bytes_sent;
    int frames_sent;
    int results_checked = 0;
    int cfg_writes;
    int mismatch_count = 0;
    int rx_cycle = 0;
    t_rx_mode rx_mode = RX_OPEN;

    // Clock.
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Run limit.
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Return every frame field of the model to its idle value.
    function automatic void clear_frame_model();
        marker_gap = sra_pkg::SINCE_MAX;
        for (int k = 0; k < 2; k++) begin
            win_fill[k]  = sra_pkg::FILL_IDLE;
            win_value[k] = 0;
            win_bad[k]   = 1'b0;
            win_dot[k]   = 1'b0;
        end
        prefix_total      = 0;
        prefix_readings   = 0;
        stored_readings   = 0;
        zero_reading_seen = 1'b0;
    endfunction

    // Advance the model by one byte; returns 1 when the byte ends a frame.
    function automatic bit predict_range(input logic [7:0] b, input logic last,
                                         output t_range_result res);
        int gap;
        res = '0;
        // Open windows take the byte before a new window may start on it.
        for (int k = 0; k < 2; k++) begin
            if (win_fill[k] != sra_pkg::FILL_IDLE) begin
                if (b >= sra_pkg::CH_0 && b <= sra_pkg::CH_9) begin
                    if (!win_dot[k])
                        win_value[k] = win_value[k] * 10 + (int'(b) - int'(sra_pkg::CH_0));
                end else if (b == sra_pkg::CH_DOT) begin
                    if (win_dot[k])
                        win_bad[k] = 1'b1;
                    win_dot[k] = 1'b1;
                end else begin
                    win_bad[k] = 1'b1;
                end
                win_fill[k]++;
                if (win_fill[k] > sra_pkg::FILL_LAST) begin
                    if (!win_bad[k] && stored_readings < STORE_LIMIT) begin
                        stored_readings++;
                        if (!zero_reading_seen) begin
                            if (win_value[k] == 0) begin
                                zero_reading_seen = 1'b1;
                            end else begin
                                prefix_total += win_value[k];
                                prefix_readings++;
                            end
                        end
                    end
                    win_fill[k]  = sra_pkg::FILL_IDLE;
                    win_value[k] = 0;
                    win_bad[k]   = 1'b0;
                    win_dot[k]   = 1'b0;
                end
            end
        end

        // A marker counts only three or more bytes after the last one.
        gap = (marker_gap + 1 > sra_pkg::SINCE_MAX) ? sra_pkg::SINCE_MAX : marker_gap + 1;
        if (b == sra_pkg::CH_R && gap >= sra_pkg::SINCE_MAX) begin
            marker_gap = 0;
            if (win_fill[0] == sra_pkg::FILL_IDLE)
                win_fill[0] = sra_pkg::FILL_OPEN;
            else if (win_fill[1] == sra_pkg::FILL_IDLE)
                win_fill[1] = sra_pkg::FILL_OPEN;
        end else begin
            marker_gap = gap;
        end

        if (!last)
            return 1'b0;

        res.reading_count = (sra_pkg::COUNT_OUT_W)'(stored_readings);
        if (stored_readings > min_count && prefix_readings != 0) begin
            res.distance      = (sra_pkg::VALUE_W)'(prefix_total / prefix_readings);
            res.average_valid = 1'b1;
        end
        clear_frame_model();
        return 1'b1;
    endfunction

    // Send one byte beat; the sender idles between bursts of random length.
    task automatic send_sonar_byte(input logic [7:0] b, input logic last);
        t_range_result want;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.frame_end <= last;
        do @(posedge i_clk); while (!in_if.ready);
        if (predict_range(b, last, want))
            expected_ranges.push_back(want);
        burst_left--;
        bytes_sent++;
        if (last)
            frames_sent++;
        @(negedge i_clk);
    endtask

    // Send a text as one frame, the last character marked as frame end.
    task automatic send_sonar_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_sonar_byte(text[i], i == text.len() - 1);
    endtask

    // Write the threshold register; only called while the block is idle.
    task automatic write_min_count(input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= (sra_pkg::MIN_W)'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        min_count = value;
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait for every pending result, then let the divider settle.
    task automatic wait_frames_done();
        in_if.valid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Build one random frame and send it.
    task automatic send_random_frame();
        logic [7:0] frame_q [$];
        logic [7:0] digits [4];
        t_reading_shape shape;
        int kind;
        int pick;
        int n_read;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // Pure noise frame.
            repeat ($urandom_range(1, 40))
                frame_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            // Well-formed readings with random content; a few overflow the store.
            n_read = (kind == 1) ? $urandom_range(30, 36) : $urandom_range(0, 12);
            repeat ($urandom_range(0, 3))
                frame_q.push_back(8'($urandom_range(0, 255)));
            repeat (n_read) begin
                pick  = $urandom_range(0, 15);
                shape = (pick < int'(SHAPE_PLAIN)) ? t_reading_shape'(pick) : SHAPE_PLAIN;
                for (int j = 0; j < 4; j++)
                    digits[j] = sra_pkg::CH_0 + 8'($urandom_range(0, 9));
                case (shape)
                    SHAPE_ZERO: begin
                        for (int j = 0; j < 4; j++)
                            digits[j] = sra_pkg::CH_0;
                    end
                    SHAPE_DOT: begin
                        digits[$urandom_range(0, 3)] = sra_pkg::CH_DOT;
                    end
                    SHAPE_TWO_DOTS: begin
                        digits[$urandom_range(0, 1)] = sra_pkg::CH_DOT;
                        digits[$urandom_range(2, 3)] = sra_pkg::CH_DOT;
                    end
                    SHAPE_BAD_BYTE: begin
                        digits[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
                    end
                    default: begin
                    end
                endcase
                frame_q.push_back(sra_pkg::CH_R);
                if (shape == SHAPE_DOUBLE_R)
                    frame_q.push_back(sra_pkg::CH_R);
                if (shape == SHAPE_OVERLAP) begin
                    // Next marker lands inside this window, so both run at once.
                    frame_q.push_back(digits[0]);
                    frame_q.push_back(digits[1]);
                end else begin
                    for (int j = 0; j < 4; j++)
                        frame_q.push_back(digits[j]);
                    repeat ($urandom_range(0, 2))
                        frame_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            // Sometimes the frame ends while a window is still open.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    if (frame_q.size() > 1)
                        void'(frame_q.pop_back());
        end
        if (frame_q.size() == 0)
            frame_q.push_back(8'($urandom_range(0, 255)));
        foreach (frame_q[i])
            send_sonar_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // A frame with nothing to store, ending on a marker on the last byte.
    task automatic test_short_frames();
        send_sonar_byte(8'h00, 1'b0);
        send_sonar_byte(8'hFF, 1'b0);
        send_sonar_byte(sra_pkg::CH_R, 1'b1);
        wait_frames_done();
    endtask

    // Largest reading and a reading cut at its dot, ending on the last byte.
    task automatic test_dot_and_mean();
        write_min_count(0);
        send_sonar_text("R9999R12.3");
        wait_frames_done();
    endtask

    // A zero reading first, then a reading with two dots.
    task automatic test_zero_reading_first();
        send_sonar_text("R.123R1.2.");
        wait_frames_done();
    endtask

    // Random frames in phases, each phase under its own threshold.
    task automatic test_random_frames();
        int start_bytes;
        int phase;
        int threshold;
        start_bytes = bytes_sent;
        phase = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (phase == 0)
                threshold = 32;
            else if (phase == 1)
                threshold = 0;
            else if ($urandom_range(0, 2) == 0)
                threshold = $urandom_range(0, 32);
            else
                threshold = $urandom_range(0, 8);
            write_min_count(threshold);
            repeat ($urandom_range(4, 8))
                send_random_frame();
            wait_frames_done();
            phase++;
        end
    endtask

    // Receiver ready, under a stall pattern that is picked anew at random.
    always @(negedge i_clk) begin
        if (rx_cycle % 48 == 0)
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   out_if.ready <= 1'b1;
            RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
            default:   out_if.ready <= ((rx_cycle % 20) < 4);
        endcase
    end

    // Compare each result beat with the oldest pending frame.
    always @(posedge i_clk) begin
        t_range_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_ranges.size() == 0) begin
                $error("result beat with no frame pending");
                mismatch_count++;
            end else begin
                want = expected_ranges.pop_front();
                results_checked++;
                if (out_if.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d",
                           want.distance, out_if.distance);
                    mismatch_count++;
                end
                if (out_if.average_valid !== want.average_valid) begin
                    $error("average_valid: expected %0d, got %0d",
                           want.average_valid, out_if.average_valid);
                    mismatch_count++;
                end
                if (out_if.reading_count !== want.reading_count) begin
                    $error("reading_count: expected %0d, got %0d",
                           want.reading_count, out_if.reading_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.frame_end  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = '0;
        burst_left       = 0;
        bytes_sent       = 0;
        frames_sent      = 0;
        cfg_writes       = 0;
        min_count        = sra_pkg::MIN_RESET;
        clear_frame_model();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_frames();
        test_dot_and_mean();
        test_zero_reading_first();
        test_random_frames();

        $display("Sent %0d bytes in %0d frames over %0d threshold writes.",
                 bytes_sent, frames_sent, cfg_writes);
        $display("Checked %0d result beats, %0d field mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
